FILE: hdl/sacl_pkg.sv
package sacl_pkg;

    localparam int SET_COUNT   = 64;
    localparam int WAYS        = 4;
    localparam int BLOCK_BYTES = 32;
    localparam int ADDR_W      = 32;

    localparam int OFS_W = $clog2(BLOCK_BYTES);
    localparam int IDX_W = $clog2(SET_COUNT);
    localparam int TAG_W = ADDR_W - OFS_W - IDX_W;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    typedef logic [WAY_W-1:0] t_age;
    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic              action;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic [1:0]        way_used;
        logic              evict_dirty;
        logic [ADDR_W-1:0] evict_address;
    } t_rsp;

    typedef struct packed {
        logic             valid;
        logic [TAG_W-1:0] tag;
        logic             dirty;
        t_age             age;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

    localparam int ROW_W = $bits(t_row);

    // controller -> datapath
    typedef struct packed {
        logic rd_en;     // lookup read of the set row
        logic wr_en;     // write back of the updated row
        logic out_load;  // capture result into the output register
    } t_cmd;

    // contents of a set that was never written since reset
    function automatic t_row reset_row();
        t_row r;
        for (int w = 0; w < WAYS; w++) begin
            r[w].valid = 1'b0;
            r[w].tag   = '0;
            r[w].dirty = 1'b0;
            r[w].age   = WAY_W'(w);
        end
        return r;
    endfunction

endpackage

FILE: hdl/sacl_req_if.sv
interface sacl_req_if;
    import sacl_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/sacl_rsp_if.sv
interface sacl_rsp_if;
    import sacl_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/sacl_ram.sv
module sacl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: hdl/sacl_ctrl.sv
module sacl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output sacl_pkg::t_cmd o_cmd
);
    import sacl_pkg::*;

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    logic r_state, n_state;
    logic r_out_vld, n_out_vld;
    logic out_free;

    assign out_free = !r_out_vld || i_rsp_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_req_ready    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // hold the looked-up row until the output register can take the beat
                if (out_free) begin
                    o_cmd.wr_en    = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_rsp_valid = r_out_vld;
endmodule

FILE: hdl/sacl_dpath.sv
module sacl_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sacl_pkg::t_req i_req_data,
    input  sacl_pkg::t_cmd i_cmd,
    output sacl_pkg::t_rsp o_rsp_data
);
    import sacl_pkg::*;

    t_req             r_req;
    logic [SET_COUNT-1:0] r_row_vld, n_row_vld;
    t_rsp             r_rsp;

    logic [ROW_W-1:0] ram_rd;
    t_row             row, new_row;
    t_idx             rd_idx, idx;
    logic [TAG_W-1:0] tag;
    logic             hit, found;
    logic [WAY_W-1:0] hit_way, free_way, lru_way, sel;
    t_age             sel_age;
    t_way             victim;
    t_rsp             rsp;

    assign rd_idx = i_req_data.address[OFS_W +: IDX_W];
    assign idx    = r_req.address[OFS_W +: IDX_W];
    assign tag    = r_req.address[ADDR_W-1 -: TAG_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_req <= i_req_data;
        end
    end

    sacl_ram #(
        .WIDTH(ROW_W),
        .DEPTH(SET_COUNT)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (i_cmd.wr_en),
        .i_wr_addr(idx),
        .i_wr_data(new_row),
        .i_rd_en  (i_cmd.rd_en),
        .i_rd_addr(rd_idx),
        .o_rd_data(ram_rd)
    );

    // unwritten sets read as their reset contents
    assign row = r_row_vld[idx] ? t_row'(ram_rd) : reset_row();

    always_comb begin
        hit      = 1'b0;
        found    = 1'b0;
        hit_way  = '0;
        free_way = '0;
        lru_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (row[w].valid && row[w].tag == tag) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!row[w].valid) begin
                found    = 1'b1;
                free_way = WAY_W'(w);
            end
            if (row[w].age == WAY_W'(WAYS - 1)) begin
                lru_way = WAY_W'(w);
            end
        end
        if (hit) begin
            sel = hit_way;
        end else if (found) begin
            sel = free_way;
        end else begin
            sel = lru_way;
        end
    end

    assign victim  = row[sel];
    assign sel_age = victim.age;

    always_comb begin
        new_row = row;
        for (int w = 0; w < WAYS; w++) begin
            if (row[w].age < sel_age) begin
                new_row[w].age = row[w].age + 1'b1;
            end
        end
        new_row[sel].age = '0;
        if (hit) begin
            new_row[sel].dirty = row[sel].dirty | r_req.action;
        end else begin
            new_row[sel].valid = 1'b1;
            new_row[sel].tag   = tag;
            new_row[sel].dirty = r_req.action;
        end
    end

    always_comb begin
        rsp.hit           = hit;
        rsp.way_used      = 2'(sel);
        rsp.evict_dirty   = !hit && !found && victim.dirty;
        rsp.evict_address = '0;
        if (rsp.evict_dirty) begin
            rsp.evict_address = {victim.tag, idx, {OFS_W{1'b0}}};
        end
    end

    always_comb begin
        n_row_vld = r_row_vld;
        if (i_cmd.wr_en) begin
            n_row_vld[idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else begin
            r_row_vld <= n_row_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rsp <= rsp;
        end
    end

    assign o_rsp_data = r_rsp;
endmodule

FILE: hdl/set_assoc_writeback_cache_lru_unit.sv
// Tag and LRU policy controller for a 4-way, 64-set, 32-byte-block
// write-back / write-allocate cache.
// i_req (sink): one beat per access, action (0 read, 1 write) and a
// 32-bit byte address. o_rsp (source): one beat per access with hit,
// way_used, evict_dirty and evict_address (victim block address, else 0).
// Each access runs as idle then lookup: the accept cycle reads the set's row
// (tags, valid, dirty, ages of all ways) from a single-port-per-side RAM,
// the lookup state compares, picks the way and writes the row back while
// the result is loaded into the output register. That read-modify-write
// of the set row sets the rate: a new access is taken only once the
// lookup is through, and the response is valid in the cycle after the load.
// A new access is taken while an earlier response still waits; if the
// sink stalls with a response held, the lookup in flight holds until the
// output register frees, and no further access is taken meanwhile.
// Reset (synchronous, active low) clears the per-set written flags, so
// every set reads as empty with ages equal to the way number; no
// clearing pass is needed and the block is ready right after reset.
module set_assoc_writeback_cache_lru_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sacl_req_if.sink   i_req,
    sacl_rsp_if.source o_rsp
);
    import sacl_pkg::*;

    t_cmd cmd;

    // sequencing: idle / lookup and the output valid flag
    sacl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req.valid),
        .o_req_ready(i_req.ready),
        .o_rsp_valid(o_rsp.valid),
        .i_rsp_ready(o_rsp.ready),
        .o_cmd      (cmd)
    );

    // set RAM, hit / victim selection, LRU aging and result register
    sacl_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req_data(i_req.data),
        .i_cmd     (cmd),
        .o_rsp_data(o_rsp.data)
    );
endmodule
